// ===== src/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int VALUE_W = 32;
    localparam int ACT_W   = 3;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_HEAD   = 3'd0,
        ACT_PUSH_TAIL   = 3'd1,
        ACT_POP_HEAD    = 3'd2,
        ACT_POP_TAIL    = 3'd3,
        ACT_READ_HEAD   = 3'd4,
        ACT_READ_TAIL   = 3'd5,
        ACT_REMOVE_HEAD = 3'd6,
        ACT_REMOVE_TAIL = 3'd7
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic take_read;
        logic scan_issue;
        logic scan_step;
        logic shift_issue;
        logic shift_write;
        logic out_load;
    } deq_cmd_t;

    typedef struct packed {
        logic need_read;
        logic need_scan;
        logic hit;
        logic scan_end;
        logic shift_end;
        logic shift_last;
        logic out_free;
    } deq_stat_t;

endpackage

// ===== src/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_RD_WAIT  = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CMP = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_WR = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_read)
                begin
                    state_next = S_RD_WAIT;
                end
                else if (stat.need_scan)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
            begin
                cmd.take_read = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN_RD:
            begin
                cmd.scan_issue = 1'b1;
                state_next     = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = stat.shift_end ? S_DONE : S_SHIFT_RD;
                end
                else
                begin
                    state_next = stat.scan_end ? S_DONE : S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_issue = 1'b1;
                state_next      = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_write = 1'b1;
                state_next      = stat.shift_last ? S_DONE : S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/deq_dp.sv =====
`timescale 1ns / 1ps

module deq_dp
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_cmd_t           cmd,
    output deq_stat_t          stat,
    input  logic [ACT_W-1:0]   action,
    input  logic [VALUE_W-1:0] value,
    input  logic [IDX_W-1:0]   index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] result_value,
    output logic [STAT_W-1:0]  status,
    output logic [LEN_W-1:0]   length
);

    logic [ADDR_W-1:0]  head_reg,     head_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [CNT_W-1:0]   pos_reg,      pos_next;
    logic [ACT_W-1:0]   action_reg,   action_next;
    logic [DATA_W-1:0]  word_reg,     word_next;
    logic [IDX_W-1:0]   index_reg,    index_next;
    logic [DATA_W-1:0]  res_val_reg,  res_val_next;
    status_t            res_st_reg,   res_st_next;
    logic               out_vld_reg,  out_vld_next;
    logic [VALUE_W-1:0] out_val_reg,  out_val_next;
    logic [STAT_W-1:0]  out_st_reg,   out_st_next;
    logic [LEN_W-1:0]   out_len_reg,  out_len_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    action_t           act;
    logic              is_push;
    logic              is_pop;
    logic              is_read;
    logic              is_remove;
    logic              from_head;
    logic              full;
    logic              empty;
    logic              idx_miss;
    logic [CNT_W-1:0]  last_pos;
    logic [CNT_W-1:0]  read_pos;
    logic [CNT_W:0]    pos_plus1;
    logic [CNT_W:0]    pos_plus2;

    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] head,
        input logic [CNT_W-1:0]  pos
    );
        return head + pos[ADDR_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign act       = action_t'(action_reg);
    assign is_push   = (act == ACT_PUSH_HEAD) || (act == ACT_PUSH_TAIL);
    assign is_pop    = (act == ACT_POP_HEAD) || (act == ACT_POP_TAIL);
    assign is_read   = (act == ACT_READ_HEAD) || (act == ACT_READ_TAIL);
    assign is_remove = (act == ACT_REMOVE_HEAD) || (act == ACT_REMOVE_TAIL);
    assign from_head = (act == ACT_PUSH_HEAD) || (act == ACT_POP_HEAD)
                    || (act == ACT_READ_HEAD) || (act == ACT_REMOVE_HEAD);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_miss  = (CNT_W'(index_reg) >= count_reg);
    assign last_pos  = count_reg - CNT_W'(1);
    assign pos_plus1 = {1'b0, pos_reg} + (CNT_W+1)'(1);
    assign pos_plus2 = {1'b0, pos_reg} + (CNT_W+1)'(2);

    always_comb
    begin
        case (act)
            ACT_POP_TAIL:  read_pos = last_pos;
            ACT_READ_HEAD: read_pos = CNT_W'(index_reg);
            ACT_READ_TAIL: read_pos = last_pos - CNT_W'(index_reg);
            default:       read_pos = '0;
        endcase
    end

    always_comb
    begin
        stat.need_read  = (is_pop && !empty) || (is_read && !idx_miss);
        stat.need_scan  = is_remove && !empty;
        stat.hit        = (ram_rdata == word_reg);
        stat.scan_end   = from_head ? (pos_reg == last_pos) : (pos_reg == '0);
        stat.shift_end  = (pos_plus1 >= {1'b0, count_reg});
        stat.shift_last = (pos_plus2 >= {1'b0, count_reg});
        stat.out_free   = !out_vld_reg || out_ready;
    end

    always_comb
    begin
        ram_raddr = slot_of(head_reg, read_pos);
        if (cmd.scan_issue)
        begin
            ram_raddr = slot_of(head_reg, pos_reg);
        end
        else if (cmd.shift_issue)
        begin
            ram_raddr = slot_of(head_reg, pos_plus1[CNT_W-1:0]);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_of(head_reg, pos_reg);
        ram_wdata = ram_rdata;
        if (cmd.exec && is_push && !full)
        begin
            ram_we    = 1'b1;
            ram_waddr = from_head ? head_reg - ADDR_W'(1) : slot_of(head_reg, count_reg);
            ram_wdata = word_reg;
        end
        else if (cmd.shift_write)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        action_next  = action_reg;
        word_next    = word_reg;
        index_next   = index_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        out_vld_next = out_vld_reg;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        out_len_next = out_len_reg;

        if (cmd.load)
        begin
            action_next = action;
            word_next   = DATA_W'(value);
            index_next  = index;
        end

        if (cmd.exec)
        begin
            res_val_next = '0;
            res_st_next  = ST_OK;
            if (is_push)
            begin
                if (full)
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (from_head)
                    begin
                        head_next = head_reg - ADDR_W'(1);
                    end
                end
            end
            else if (is_pop || is_read)
            begin
                if (!stat.need_read)
                begin
                    res_st_next = ST_MISS;
                end
                else if (is_pop)
                begin
                    count_next = last_pos;
                    if (from_head)
                    begin
                        head_next = head_reg + ADDR_W'(1);
                    end
                end
            end
            else
            begin
                if (empty)
                begin
                    res_st_next = ST_MISS;
                end
                else
                begin
                    pos_next = from_head ? '0 : last_pos;
                end
            end
        end

        if (cmd.take_read)
        begin
            res_val_next = ram_rdata;
        end

        if (cmd.scan_step)
        begin
            if (stat.hit)
            begin
                res_val_next = word_reg;
                if (stat.shift_end)
                begin
                    count_next = last_pos;
                end
            end
            else if (stat.scan_end)
            begin
                res_st_next = ST_MISS;
            end
            else
            begin
                pos_next = from_head ? pos_reg + CNT_W'(1) : pos_reg - CNT_W'(1);
            end
        end

        if (cmd.shift_write)
        begin
            pos_next = pos_plus1[CNT_W-1:0];
            if (stat.shift_last)
            begin
                count_next = last_pos;
            end
        end

        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
            out_val_next = VALUE_W'(res_val_reg);
            out_st_next  = res_st_reg;
            out_len_next = LEN_W'(count_reg);
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        action_reg  <= action_next;
        word_reg    <= word_next;
        index_reg   <= index_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_len_reg <= out_len_next;
    end

    assign out_valid    = out_vld_reg;
    assign result_value = out_val_reg;
    assign status       = out_st_reg;
    assign length       = out_len_reg;

endmodule

// ===== src/double_ended_queue_engine_core.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of 32-bit words held in a 16-entry ring buffer (RAM with one
// write port and one registered read port, head pointer and count). One item is worked on
// at a time and every item gives exactly one result, loaded into the output register.
// An accepted push writes its word while the action executes, a pop or indexed read adds
// one RAM read, and a refused push or a missed pop or read touches no RAM. A remove by
// value reads and compares one entry at a time, then moves each later entry up one place;
// each step issues one RAM read and waits for its registered data. A new item is taken
// while the last result waits.

module double_ended_queue_engine_core
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ACT_W-1:0]   action,
    input  logic [VALUE_W-1:0] value,
    input  logic [IDX_W-1:0]   index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] result_value,
    output logic [STAT_W-1:0]  status,
    output logic [LEN_W-1:0]   length
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .value        (value),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .length       (length)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        action_t            act;
        logic [VALUE_W-1:0] word;
        logic [IDX_W-1:0]   idx;
        logic               hold;
    } deq_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        status_t            st;
        logic [LEN_W-1:0]   len;
    } deq_res_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [ACT_W-1:0]   action = ACT_PUSH_HEAD;
    logic [VALUE_W-1:0] value = '0;
    logic [IDX_W-1:0]   index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [VALUE_W-1:0] result_value;
    logic [STAT_W-1:0]  status;
    logic [LEN_W-1:0]   length;

    deq_op_t  pending_ops[$];
    deq_res_t owed_results[$];
    deq_op_t  cur_op;
    logic     in_fire = 1'b0;
    logic     out_fire = 1'b0;
    int       send_gap = 0;
    int       recv_stall = 0;
    bit       send_idle = 1'b0;
    bit       recv_idle = 1'b1;
    int       err_count = 0;
    int       cycle_count = 0;
    logic [VALUE_W-1:0] word_pool[8];

    // queue shadow
    logic [DATA_W-1:0] ring[DEPTH];
    logic [ADDR_W-1:0] ring_head = '0;
    logic [CNT_W-1:0]  ring_count = '0;

    double_ended_queue_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .value        (value),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status),
        .length       (length)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [ADDR_W-1:0] slot_at(input int pos);
        return ADDR_W'(ring_head + pos);
    endfunction

    function automatic deq_res_t run_deq_action(input deq_op_t op);
        deq_res_t r;
        int       p;
        int       q;
        bit       hit;
        r.word = '0;
        r.st = ST_OK;
        case (op.act)
            ACT_PUSH_HEAD, ACT_PUSH_TAIL:
            begin
                if (ring_count == CNT_W'(DEPTH))
                    r.st = ST_FULL;
                else if (op.act == ACT_PUSH_HEAD)
                begin
                    ring_head = ring_head - ADDR_W'(1);
                    ring[ring_head] = op.word;
                    ring_count = ring_count + CNT_W'(1);
                end
                else
                begin
                    ring[slot_at(int'(ring_count))] = op.word;
                    ring_count = ring_count + CNT_W'(1);
                end
            end
            ACT_POP_HEAD, ACT_POP_TAIL:
            begin
                if (ring_count == '0)
                    r.st = ST_MISS;
                else if (op.act == ACT_POP_HEAD)
                begin
                    r.word = ring[ring_head];
                    ring_head = ring_head + ADDR_W'(1);
                    ring_count = ring_count - CNT_W'(1);
                end
                else
                begin
                    r.word = ring[slot_at(int'(ring_count) - 1)];
                    ring_count = ring_count - CNT_W'(1);
                end
            end
            ACT_READ_HEAD, ACT_READ_TAIL:
            begin
                if (CNT_W'(op.idx) >= ring_count)
                    r.st = ST_MISS;
                else
                begin
                    p = (op.act == ACT_READ_HEAD) ? int'(op.idx)
                                                  : int'(ring_count) - 1 - int'(op.idx);
                    r.word = ring[slot_at(p)];
                end
            end
            default:
            begin
                hit = 1'b0;
                p = 0;
                if (op.act == ACT_REMOVE_HEAD)
                begin
                    for (q = 0; q < int'(ring_count) && !hit; q++)
                        if (ring[slot_at(q)] == op.word)
                        begin
                            hit = 1'b1;
                            p = q;
                        end
                end
                else
                begin
                    for (q = int'(ring_count) - 1; q >= 0 && !hit; q--)
                        if (ring[slot_at(q)] == op.word)
                        begin
                            hit = 1'b1;
                            p = q;
                        end
                end
                if (hit)
                begin
                    r.word = ring[slot_at(p)];
                    // later entries move up one place
                    for (q = p; q + 1 < int'(ring_count); q++)
                        ring[slot_at(q)] = ring[slot_at(q + 1)];
                    ring_count = ring_count - CNT_W'(1);
                end
                else
                    r.st = ST_MISS;
            end
        endcase
        r.len = ring_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic add_op(input action_t a, input logic [VALUE_W-1:0] w,
                          input logic [IDX_W-1:0] i, input bit h);
        deq_op_t op;
        op.act = a;
        op.word = w;
        op.idx = i;
        op.hold = h;
        pending_ops.push_back(op);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return word_pool[$urandom_range(0, 7)];
        else if (r == 6)
            return '0;
        else if (r == 7)
            return '1;
        return $urandom;
    endfunction

    function automatic action_t pick_action(input int mode);
        int r;
        bit tail;
        r = $urandom_range(0, 99);
        tail = 1'($urandom_range(0, 1));
        if (mode == 0)
        begin
            // filling up
            if (r < 60)
                return tail ? ACT_PUSH_TAIL : ACT_PUSH_HEAD;
            if (r < 80)
                return tail ? ACT_READ_TAIL : ACT_READ_HEAD;
        end
        else if (mode == 1)
        begin
            // emptying
            if (r < 40)
                return tail ? ACT_POP_TAIL : ACT_POP_HEAD;
            if (r < 75)
                return tail ? ACT_REMOVE_TAIL : ACT_REMOVE_HEAD;
            if (r < 90)
                return tail ? ACT_READ_TAIL : ACT_READ_HEAD;
            return tail ? ACT_PUSH_TAIL : ACT_PUSH_HEAD;
        end
        return action_t'($urandom_range(0, 7));
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].hold && owed_results.size() != 0))
                begin
                    cur_op = pending_ops.pop_front();
                    action <= cur_op.act;
                    value <= cur_op.word;
                    index <= cur_op.idx;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        send_idle = !send_idle;
                    send_gap = send_idle ? $urandom_range(0, 15) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 31) == 0)
                    recv_idle = !recv_idle;
                recv_stall = recv_idle ? $urandom_range(0, 15) : 0;
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        deq_res_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            out_fire <= out_valid && out_ready;
            if (in_valid && in_ready)
                owed_results.push_back(run_deq_action(cur_op));
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected item, value", result_value, '0);
                else
                begin
                    want = owed_results.pop_front();
                    if (result_value !== want.word)
                        report_mismatch("result_value", result_value, want.word);
                    if (status !== want.st)
                        report_mismatch("status", VALUE_W'(status), VALUE_W'(want.st));
                    if (length !== want.len)
                        report_mismatch("length", VALUE_W'(length), VALUE_W'(want.len));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int  k;
        int  n;
        int  j;
        int  mode;
        int  run;
        bit  hold;
        for (k = 0; k < 8; k++)
            word_pool[k] = $urandom;

        // empty queue misses
        add_op(ACT_POP_TAIL, '0, '0, 1'b0);
        add_op(ACT_REMOVE_HEAD, '0, '0, 1'b0);
        // fill from both ends, zero and all-ones words among them
        for (k = 0; k < DEPTH; k++)
            add_op(k[0] ? ACT_PUSH_TAIL : ACT_PUSH_HEAD,
                   (k == 0) ? '0 : (k == 1) ? '1 : $urandom, k[IDX_W-1:0], 1'b0);
        add_op(ACT_PUSH_TAIL, 32'h1234_5678, '0, 1'b0);
        add_op(ACT_READ_HEAD, '0, 4'd15, 1'b0);
        add_op(ACT_READ_TAIL, '0, 4'd15, 1'b0);
        add_op(ACT_REMOVE_TAIL, '0, '0, 1'b0);
        add_op(ACT_REMOVE_HEAD, '1, '0, 1'b0);
        add_op(ACT_REMOVE_TAIL, 32'h1234_5678, '0, 1'b0);
        add_op(ACT_POP_HEAD, '0, '0, 1'b0);
        add_op(ACT_POP_TAIL, '0, '0, 1'b0);
        add_op(ACT_READ_HEAD, '0, 4'd15, 1'b0);

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            run = $urandom_range(8, 40);
            hold = (n == 0) || ($urandom_range(0, 5) == 0);
            for (j = 0; j < run; j++)
            begin
                add_op(pick_action(mode), pick_word(),
                       IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 15)),
                       hold && j == 0);
                n++;
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && owed_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
